### design/dpat_pkg.sv
// dpat_pkg: shared types, codes and reset constants of the address translator
// used by the controller, the datapath, the top level and the checker
// no dependencies
package dpat_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int FRAME_NUM_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SPACE_W     = 6;
    localparam int OFFSET_W    = 5;

    // default table sizes
    localparam int PAGE_SLOTS_DEF  = 256;
    localparam int FRAME_SLOTS_DEF = 256;

    // register reset values
    localparam logic [SPACE_W-1:0]  LOGICAL_BITS_RST  = 6'd16;
    localparam logic [SPACE_W-1:0]  PHYSICAL_BITS_RST = 6'd16;
    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST   = 5'd8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOGICAL_BITS  = 2'd0,
        CFG_PHYSICAL_BITS = 2'd1,
        CFG_OFFSET_BITS   = 2'd2
    } t_cfg_idx;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_FRAME = 2'd2
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch request, start page table read
        logic commit;   // resolve lookup, update tables, load result
    } t_dp_cmd;

endpackage

### design/dpat_ctrl.sv
// dpat_ctrl: controller state machine of the address translator
// sequences capture and commit, owns the handshakes; depends on dpat_pkg
module dpat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dpat_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // result slot can take a new result this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/dpat_datapath.sv
// dpat_datapath: configuration registers, page table, frame map and result register
// driven by dpat_ctrl commands; depends on dpat_pkg
module dpat_datapath #(
    parameter int PAGE_SLOTS  = dpat_pkg::PAGE_SLOTS_DEF,
    parameter int FRAME_SLOTS = dpat_pkg::FRAME_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dpat_pkg::t_dp_cmd                  i_cmd,
    input  logic                               i_cfg_valid,
    input  logic [dpat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dpat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [dpat_pkg::ADDR_W-1:0]        i_logical_address,
    output logic [dpat_pkg::ADDR_W-1:0]        o_physical_address,
    output logic [dpat_pkg::ADDR_W-1:0]        o_page_number,
    output logic [dpat_pkg::FRAME_NUM_W-1:0]   o_frame_number,
    output logic                               o_page_fault,
    output logic [1:0]                         o_status
);

    localparam int PAGE_AW  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int FRAME_AW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int AW       = dpat_pkg::ADDR_W;
    localparam int LIM_W    = dpat_pkg::ADDR_W + 1;

    // slot count 2^(space - off), negative exponent as zero, clamped to slots
    function automatic logic [LIM_W-1:0] slot_limit(
        input logic [dpat_pkg::SPACE_W-1:0]  space,
        input logic [dpat_pkg::OFFSET_W-1:0] off,
        input logic [LIM_W-1:0]              slots
    );
        logic [dpat_pkg::SPACE_W-1:0] e;
        logic [LIM_W-1:0]             n;
        e = (space > {1'b0, off}) ? (space - {1'b0, off}) : '0;
        n = {{(LIM_W-1){1'b0}}, 1'b1} << e[4:0];
        if (e >= 6'd32) begin
            slot_limit = slots;
        end else begin
            slot_limit = (n < slots) ? n : slots;
        end
    endfunction

    // configuration registers
    logic [dpat_pkg::SPACE_W-1:0]  r_logical_bits;
    logic [dpat_pkg::SPACE_W-1:0]  r_physical_bits;
    logic [dpat_pkg::OFFSET_W-1:0] r_offset_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical_bits  <= dpat_pkg::LOGICAL_BITS_RST;
            r_physical_bits <= dpat_pkg::PHYSICAL_BITS_RST;
            r_offset_bits   <= dpat_pkg::OFFSET_BITS_RST;
        end else if (i_cfg_valid) begin
            case (dpat_pkg::t_cfg_idx'(i_cfg_index))
                dpat_pkg::CFG_LOGICAL_BITS:  r_logical_bits  <= i_cfg_data;
                dpat_pkg::CFG_PHYSICAL_BITS: r_physical_bits <= i_cfg_data;
                dpat_pkg::CFG_OFFSET_BITS:
                    r_offset_bits <= i_cfg_data[dpat_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // split the incoming address
    logic [AW-1:0]      in_page, in_offset;
    logic [LIM_W-1:0]   pages_lim, frames_lim;
    logic [PAGE_AW-1:0] in_page_idx;

    always_comb begin
        in_page     = i_logical_address >> r_offset_bits;
        in_offset   = i_logical_address & ((AW'(1) << r_offset_bits) - AW'(1));
        pages_lim   = slot_limit(r_logical_bits, r_offset_bits, LIM_W'(PAGE_SLOTS));
        frames_lim  = slot_limit(r_physical_bits, r_offset_bits, LIM_W'(FRAME_SLOTS));
        in_page_idx = in_page[PAGE_AW-1:0];
    end

    // captured request
    logic [AW-1:0]      r_page_num, r_offset;
    logic [PAGE_AW-1:0] r_page_idx;
    logic [LIM_W-1:0]   r_frames_lim;
    logic               r_in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page_num   <= in_page;
            r_offset     <= in_offset;
            r_page_idx   <= in_page_idx;
            r_frames_lim <= frames_lim;
            r_in_range   <= ({1'b0, in_page} < pages_lim);
        end
    end

    // page-to-frame memory, read on capture, written on commit
    logic [FRAME_AW-1:0] page_frame_mem [PAGE_SLOTS];
    logic [FRAME_AW-1:0] r_rd_frame;
    logic                do_map;
    logic [FRAME_AW-1:0] free_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_frame <= page_frame_mem[in_page_idx];
        end
        if (do_map) begin
            page_frame_mem[r_page_idx] <= free_idx;
        end
    end

    // lowest free frame: isolate lowest set bit, then encode
    logic [FRAME_SLOTS-1:0] r_frame_used;
    logic [FRAME_SLOTS-1:0] free_vec, lowest;
    logic                   free_found;

    always_comb begin
        free_vec = ~r_frame_used;
        lowest   = free_vec & (~free_vec + {{(FRAME_SLOTS-1){1'b0}}, 1'b1});
        free_idx = '0;
        for (int b = 0; b < FRAME_AW; b++) begin
            for (int f = 0; f < FRAME_SLOTS; f++) begin
                if (((f >> b) & 1) == 1) begin
                    free_idx[b] = free_idx[b] | lowest[f];
                end
            end
        end
        free_found = (|free_vec) && ({{(LIM_W-FRAME_AW){1'b0}}, free_idx} < r_frames_lim);
    end

    // resolve the lookup
    logic [PAGE_SLOTS-1:0] r_page_valid;
    logic                  hit;
    logic [FRAME_AW-1:0]   res_frame;
    logic                  res_fault;
    dpat_pkg::t_status     res_status;
    logic [AW-1:0]         res_phys;

    always_comb begin
        hit        = r_page_valid[r_page_idx];
        do_map     = 1'b0;
        res_frame  = '0;
        res_fault  = 1'b0;
        res_status = dpat_pkg::ST_OK;
        res_phys   = '0;
        if (!r_in_range) begin
            res_status = dpat_pkg::ST_RANGE;
        end else if (hit) begin
            res_frame = r_rd_frame;
            res_phys  = (AW'(r_rd_frame) << r_offset_bits) | r_offset;
        end else begin
            res_fault = 1'b1;
            if (free_found) begin
                do_map    = i_cmd.commit;
                res_frame = free_idx;
                res_phys  = (AW'(free_idx) << r_offset_bits) | r_offset;
            end else begin
                res_status = dpat_pkg::ST_NO_FRAME;
            end
        end
    end

    // valid and used bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_valid <= '0;
            r_frame_used <= '0;
        end else if (do_map) begin
            r_page_valid[r_page_idx] <= 1'b1;
            r_frame_used[free_idx]   <= 1'b1;
        end
    end

    // result register
    logic [AW-1:0]                    r_out_phys, r_out_page;
    logic [dpat_pkg::FRAME_NUM_W-1:0] r_out_frame;
    logic                             r_out_fault;
    logic [1:0]                       r_out_status;
    logic [AW-1:0]                    frame_wide;

    assign frame_wide = AW'(res_frame);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_phys   <= res_phys;
            r_out_page   <= r_page_num;
            r_out_frame  <= frame_wide[dpat_pkg::FRAME_NUM_W-1:0];
            r_out_fault  <= res_fault;
            r_out_status <= res_status;
        end
    end

    assign o_physical_address = r_out_phys;
    assign o_page_number      = r_out_page;
    assign o_frame_number     = r_out_frame;
    assign o_page_fault       = r_out_fault;
    assign o_status           = r_out_status;

endmodule

### design/demand_paging_address_translator_core.sv
// a request is accepted with capture, which starts the registered page table read; commit
//   then resolves the lookup, updates the tables and loads the result register; a new request
//   is taken only once the previous one has committed; a waiting result holds commit until taken
// reset: synchronous active low; clears control state, configuration registers, page valid and frame used bits
//   at once (no clearing pass); page frame entries are undefined until written
// depends on dpat_pkg, dpat_ctrl, dpat_datapath
module demand_paging_address_translator_core #(
    parameter int PAGE_SLOTS  = dpat_pkg::PAGE_SLOTS_DEF,
    parameter int FRAME_SLOTS = dpat_pkg::FRAME_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dpat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dpat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dpat_pkg::ADDR_W-1:0]        i_logical_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dpat_pkg::ADDR_W-1:0]        o_physical_address,
    output logic [dpat_pkg::ADDR_W-1:0]        o_page_number,
    output logic [dpat_pkg::FRAME_NUM_W-1:0]   o_frame_number,
    output logic                               o_page_fault,
    output logic [1:0]                         o_status
);

    dpat_pkg::t_dp_cmd cmd;

    // configuration writes always taken
    assign o_cfg_ready = 1'b1;

    dpat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dpat_datapath #(
        .PAGE_SLOTS  (PAGE_SLOTS),
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_logical_address  (i_logical_address),
        .o_physical_address (o_physical_address),
        .o_page_number      (o_page_number),
        .o_frame_number     (o_frame_number),
        .o_page_fault       (o_page_fault),
        .o_status           (o_status)
    );

endmodule

### design/dpat_checker.sv
// dpat_checker: port-level assertions on the address translator, plus its bind
// depends on dpat_pkg and demand_paging_address_translator_core
module dpat_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [dpat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [dpat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic [dpat_pkg::ADDR_W-1:0]        i_logical_address,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [dpat_pkg::ADDR_W-1:0]        o_physical_address,
    input logic [dpat_pkg::ADDR_W-1:0]        o_page_number,
    input logic [dpat_pkg::FRAME_NUM_W-1:0]   o_frame_number,
    input logic                               o_page_fault,
    input logic [1:0]                         o_status
);

    // one request at a time: no new request the cycle after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one in flight");

    // a stalled result keeps its physical address, frame number and status
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_physical_address) && $stable(o_status)
             && $stable(o_frame_number)))
        else $error("result changed while stalled");

    // out of range page: no fault, no translation
    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dpat_pkg::ST_RANGE) |->
            (!o_page_fault && o_frame_number == '0 && o_physical_address == '0))
        else $error("out of range result not cleared");

    // no free frame: fault raised, no translation
    a_no_frame_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dpat_pkg::ST_NO_FRAME) |->
            (o_page_fault && o_frame_number == '0 && o_physical_address == '0))
        else $error("no free frame result malformed");

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind demand_paging_address_translator_core dpat_checker u_dpat_checker (.*);
